@@ src/wcb_pkg.sv @@
// ----------------------------------------------------------------------------
// wcb_pkg: shared definitions for the write combining buffer
// Sizes, configuration register codes and channel word layouts.
// ----------------------------------------------------------------------------
package wcb_pkg;

    // byte store depth and derived widths
    localparam int BUF_DEPTH = 32;
    localparam int PTR_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    // field widths
    localparam int OFF_W     = 25;
    localparam int SIZE_W    = 26;
    localparam int FLEN_W    = 6;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;

    // smallest usable flush length
    localparam int MIN_FLUSH = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_LENGTH = 2'd2;

    // configuration reset values
    localparam logic [OFF_W-1:0]  RST_REGION_START = '0;
    localparam logic [SIZE_W-1:0] RST_REGION_SIZE  = 26'h200_0000;
    localparam logic [FLEN_W-1:0] RST_FLUSH_LENGTH = 6'd32;

    typedef struct packed {
        logic [OFF_W-1:0]  byte_offset;
        logic [BYTE_W-1:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [OFF_W-1:0]  burst_address;
        logic [BYTE_W-1:0] write_byte;
        logic              burst_last;
    } t_out_word;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [SIZE_W-1:0]    wdata;
    } t_cfg_word;

endpackage

@@ src/wcb_if.sv @@
// ----------------------------------------------------------------------------
// wcb_if: valid/ready channels of the write combining buffer
// Input byte channel, output burst byte channel and configuration channel.
// ----------------------------------------------------------------------------
interface wcb_in_if import wcb_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

interface wcb_out_if import wcb_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

interface wcb_cfg_if import wcb_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

@@ src/write_combining_buffer.sv @@
// ----------------------------------------------------------------------------
// write_combining_buffer: gathers contiguous bytes into bursts
// Bytes at contiguous offsets collect in a byte store; bursts go out one byte
// per word with their start address and a last flag, wrapping at region end.
// ----------------------------------------------------------------------------
// An input word is taken in ST_IDLE and checked against the flush length in
// ST_CHECK in the cycle after. The bytes of each burst are read from the
// single-port byte store, one read per cycle, into a two-word output queue,
// so a burst streams at one byte per cycle while the sink keeps up. After a
// burst closed by the flush length the next input word is taken as soon as
// the last read is issued; a burst flushed by a break in contiguity is
// followed by the check cycle of the word that broke the run. The byte store
// is a circular buffer; the bytes kept after a wrap are not moved. There is
// no clearing pass after reset, and configuration words are taken at any
// time.
module write_combining_buffer import wcb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wcb_in_if.sink    i_in,
    wcb_cfg_if.sink   i_cfg,
    wcb_out_if.source o_out
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EMIT_A = 2'd1;
    localparam logic [1:0] ST_CHECK  = 2'd2;
    localparam logic [1:0] ST_EMIT_B = 2'd3;

    // circular pointer add, n at most the depth
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] n);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(p) + (CNT_W+1)'(n);
        if (s >= (CNT_W+1)'(BUF_DEPTH)) s = s - (CNT_W+1)'(BUF_DEPTH);
        return s[PTR_W-1:0];
    endfunction

    // configuration registers
    logic [OFF_W-1:0]  r_region_start;
    logic [SIZE_W-1:0] r_region_size;
    logic [FLEN_W-1:0] r_flush_len;

    // buffer state
    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_pend, n_pend;
    logic [PTR_W-1:0] r_head, n_head;
    logic [OFF_W-1:0] r_bo, n_bo;
    logic [OFF_W-1:0] r_exp, n_exp;

    // burst being read out
    logic [PTR_W-1:0] r_em_ptr, n_em_ptr;
    logic [CNT_W-1:0] r_em_left, n_em_left;
    logic [OFF_W-1:0] r_em_addr, n_em_addr;

    // byte store and its read stage
    logic [BYTE_W-1:0] r_mem [BUF_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;
    logic [OFF_W-1:0]  r_rd_addr;
    logic              r_rd_last;
    logic              r_rd_vld;

    // output queue
    t_out_word r_q [2];
    logic      r_q_wp;
    logic      r_q_rp;
    logic [1:0] r_q_cnt;

    logic             in_acc;
    logic             pop;
    logic             issue;
    logic [1:0]       occ;
    logic [CNT_W-1:0] flen;
    logic             flush1;
    logic [CNT_W-1:0] p0;
    logic [PTR_W-1:0] wr_ptr;
    logic [SIZE_W-1:0] burst_end;
    logic [SIZE_W-1:0] tail_len;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;

    assign o_out.valid = (r_q_cnt != 2'd0);
    assign o_out.word  = r_q[r_q_rp];
    assign pop         = o_out.valid && o_out.ready;

    // read issue while the queue and the read stage have room
    assign occ   = r_q_cnt + {1'b0, r_rd_vld};
    assign issue = ((r_state == ST_EMIT_A) || (r_state == ST_EMIT_B)) &&
                   (r_em_left != '0) && ((occ < 2'd2) || pop);

    // effective flush length
    always_comb begin
        priority if (r_flush_len < FLEN_W'(MIN_FLUSH)) begin
            flen = CNT_W'(MIN_FLUSH);
        end else if (32'(r_flush_len) > 32'(BUF_DEPTH)) begin
            flen = CNT_W'(BUF_DEPTH);
        end else begin
            flen = CNT_W'(r_flush_len);
        end
    end

    assign flush1    = (i_in.word.byte_offset != r_exp) && (r_pend != '0);
    assign p0        = flush1 ? '0 : r_pend;
    assign wr_ptr    = ptr_add(r_head, r_pend);
    assign burst_end = {1'b0, r_bo} + SIZE_W'(r_pend);
    assign tail_len  = r_region_size - {1'b0, r_bo};

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_pend    = r_pend;
        n_head    = r_head;
        n_bo      = r_bo;
        n_exp     = r_exp;
        n_em_ptr  = r_em_ptr;
        n_em_left = r_em_left;
        n_em_addr = r_em_addr;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (flush1) begin
                        n_em_ptr  = r_head;
                        n_em_left = r_pend;
                        n_em_addr = r_region_start + r_bo;
                        n_head    = wr_ptr;
                        n_state   = ST_EMIT_A;
                    end else begin
                        n_state   = ST_CHECK;
                    end
                    n_pend = p0 + CNT_W'(1);
                    if (p0 == '0) begin
                        n_bo  = i_in.word.byte_offset;
                        n_exp = i_in.word.byte_offset + OFF_W'(1);
                    end else begin
                        n_exp = r_exp + OFF_W'(1);
                    end
                end
            end
            ST_CHECK: begin
                if (r_pend >= flen) begin
                    n_em_ptr  = r_head;
                    n_em_addr = r_region_start + r_bo;
                    n_state   = ST_EMIT_B;
                    if (({1'b0, r_bo} >= r_region_size) || (burst_end <= r_region_size)) begin
                        n_em_left = r_pend;
                        n_head    = ptr_add(r_head, r_pend);
                        n_pend    = '0;
                    end else begin
                        n_em_left = tail_len[CNT_W-1:0];
                        n_head    = ptr_add(r_head, tail_len[CNT_W-1:0]);
                        n_pend    = r_pend - tail_len[CNT_W-1:0];
                        n_bo      = '0;
                        n_exp     = OFF_W'(r_pend - tail_len[CNT_W-1:0]);
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT_A, ST_EMIT_B: begin
                if (issue) begin
                    n_em_ptr  = ptr_add(r_em_ptr, CNT_W'(1));
                    n_em_left = r_em_left - CNT_W'(1);
                    if (r_em_left == CNT_W'(1)) begin
                        n_state = (r_state == ST_EMIT_A) ? ST_CHECK : ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pend    <= '0;
            r_head    <= '0;
            r_bo      <= '0;
            r_exp     <= '0;
            r_em_left <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_head    <= n_head;
            r_bo      <= n_bo;
            r_exp     <= n_exp;
            r_em_left <= n_em_left;
            r_rd_vld  <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_em_ptr  <= n_em_ptr;
        r_em_addr <= n_em_addr;
    end

    // configuration words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_start <= RST_REGION_START;
            r_region_size  <= RST_REGION_SIZE;
            r_flush_len    <= RST_FLUSH_LENGTH;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.word.index)
                CFG_REGION_START: r_region_start <= i_cfg.word.wdata[OFF_W-1:0];
                CFG_REGION_SIZE:  r_region_size  <= i_cfg.word.wdata;
                CFG_FLUSH_LENGTH: r_flush_len    <= i_cfg.word.wdata[FLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // byte store: write on accept, registered read on issue
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem[wr_ptr] <= i_in.word.data_byte;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_em_ptr];
            r_rd_addr <= r_em_addr;
            r_rd_last <= (r_em_left == CNT_W'(1));
        end
    end

    // output queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wp  <= 1'b0;
            r_q_rp  <= 1'b0;
            r_q_cnt <= 2'd0;
        end else begin
            if (r_rd_vld) r_q_wp <= ~r_q_wp;
            if (pop)      r_q_rp <= ~r_q_rp;
            r_q_cnt <= r_q_cnt + {1'b0, r_rd_vld} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_q[r_q_wp] <= '{burst_address: r_rd_addr, write_byte: r_rd_data,
                             burst_last: r_rd_last};
        end
    end

endmodule

@@ verif/write_combining_buffer_tb.sv @@
// ----------------------------------------------------------------------------
// write_combining_buffer_tb: self-checking bench for the write combining buffer
// Drives offset/byte words with bursty gaps, stalls the burst output on its own
// pattern, and checks every burst byte against a cycle-free model of the
// combining rules: contiguity flush, flush length, region end wrap.
// ----------------------------------------------------------------------------
module write_combining_buffer_tb;
    import wcb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [OFF_W-1:0]  off_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [SIZE_W-1:0] span_t;

    localparam off_t OFF_MAX = '1;
    // index with no register behind it, writes to it change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    // cycles allowed for a word that closes no burst to settle
    localparam int SETTLE_CYCLES = 16;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    wcb_in_if  in_ch ();
    wcb_cfg_if cfg_ch ();
    wcb_out_if out_ch ();

    write_combining_buffer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always #1 i_clk = ~i_clk;

    // model copy of the registers
    off_t             cfg_base;
    span_t            cfg_size;
    logic [FLEN_W-1:0] cfg_flen;

    // model copy of the gathering state
    byte_t       held_bytes [BUF_DEPTH];
    int unsigned held_count;
    off_t        run_start;
    off_t        next_offset;

    // burst bytes the block still owes, oldest first
    t_out_word burst_bytes_due [$];

    int fail_count = 0;
    int stall_pct  = 30;
    int hold_left  = 0;
    int gap_max    = 2;
    int burst_left = 0;
    off_t last_off = '0;
    t_out_word due_word;

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------
    function automatic void reset_model();
        cfg_base    = RST_REGION_START;
        cfg_size    = RST_REGION_SIZE;
        cfg_flen    = RST_FLUSH_LENGTH;
        held_count  = 0;
        run_start   = '0;
        next_offset = '0;
        for (int i = 0; i < BUF_DEPTH; i++) held_bytes[i] = '0;
        burst_bytes_due.delete();
    endfunction

    // queue the first count held bytes as one burst
    function automatic void issue_burst(input int unsigned count);
        off_t      addr;
        t_out_word w;
        addr = cfg_base + run_start;
        for (int unsigned i = 0; i < count && i < BUF_DEPTH; i++) begin
            w.burst_address = addr;
            w.write_byte    = held_bytes[i];
            w.burst_last    = (i + 1 == count);
            burst_bytes_due.push_back(w);
        end
    endfunction

    function automatic void gather_byte(input off_t off, input byte_t data);
        int unsigned     flen;
        int unsigned     tail;
        int unsigned     keep_len;
        longint unsigned run_end;
        flen = int'(cfg_flen);
        if (flen < MIN_FLUSH) flen = MIN_FLUSH;
        if (flen > BUF_DEPTH) flen = BUF_DEPTH;

        // a break in contiguity closes the pending run
        if (off != next_offset && held_count != 0) begin
            issue_burst(held_count);
            held_count  = 0;
            next_offset = off;
        end
        if (held_count == 0) begin
            run_start   = off;
            next_offset = off;
        end
        if (held_count < BUF_DEPTH) begin
            held_bytes[held_count] = data;
            held_count++;
        end
        next_offset = next_offset + 1'b1;

        // flush length reached: whole run, or the part up to region end
        if (held_count >= flen) begin
            run_end = longint'(run_start) + held_count;
            if (span_t'(run_start) >= cfg_size || run_end <= longint'(cfg_size)) begin
                issue_burst(held_count);
                held_count = 0;
            end else begin
                tail     = int'(cfg_size - span_t'(run_start));
                keep_len = held_count - tail;
                issue_burst(tail);
                for (int unsigned i = 0; i < keep_len; i++)
                    held_bytes[i] = held_bytes[i + tail];
                held_count  = keep_len;
                run_start   = '0;
                next_offset = off_t'(keep_len);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // burst output: stall pattern and checking
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(0, 199) == 0) begin
            hold_left = $urandom_range(5, 30);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (burst_bytes_due.size() == 0) begin
                $error("burst word with none due: address %h byte %h last %b",
                       out_ch.word.burst_address, out_ch.word.write_byte,
                       out_ch.word.burst_last);
                fail_count++;
            end else begin
                due_word = burst_bytes_due.pop_front();
                if (out_ch.word.burst_address !== due_word.burst_address) begin
                    $error("burst_address: expected %h, got %h",
                           due_word.burst_address, out_ch.word.burst_address);
                    fail_count++;
                end
                if (out_ch.word.write_byte !== due_word.write_byte) begin
                    $error("write_byte: expected %h, got %h",
                           due_word.write_byte, out_ch.word.write_byte);
                    fail_count++;
                end
                if (out_ch.word.burst_last !== due_word.burst_last) begin
                    $error("burst_last: expected %b, got %b",
                           due_word.burst_last, out_ch.word.burst_last);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    // one input word, sent in bursts with random gaps between them
    task automatic send_byte(input off_t off, input byte_t data);
        t_in_word    w;
        int unsigned gap;
        w.byte_offset = off;
        w.data_byte   = data;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_ch.valid <= 1'b1;
        in_ch.word  <= w;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        gather_byte(off, data);
        burst_left--;
        last_off = off;
    endtask

    // stop sending and wait until every owed burst byte is out
    task automatic drain_writes();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (burst_bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // leaves valid high so back-to-back writes need no extra cycle
    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input span_t value);
        t_cfg_word w;
        w.index = idx;
        w.wdata = value;
        cfg_ch.valid <= 1'b1;
        cfg_ch.word  <= w;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
        case (idx)
            CFG_REGION_START: cfg_base = value[OFF_W-1:0];
            CFG_REGION_SIZE:  cfg_size = value;
            CFG_FLUSH_LENGTH: cfg_flen = value[FLEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input span_t start_val, input span_t size_val,
                                input span_t flen_val, input bit spare);
        if (spare) set_register(CFG_UNMAPPED, span_t'($urandom));
        set_register(CFG_REGION_START, start_val);
        set_register(CFG_REGION_SIZE, size_val);
        set_register(CFG_FLUSH_LENGTH, flen_val);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // random picks
    // ------------------------------------------------------------------------
    function automatic span_t pick_start();
        span_t v;
        v = span_t'($urandom);
        case ($urandom_range(0, 3))
            0: v[OFF_W-1:0] = '0;
            1: v[OFF_W-1:0] = OFF_MAX;
            default: ;
        endcase
        return v;
    endfunction

    function automatic span_t pick_size();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return span_t'(1);
            2: return span_t'(2);
            3: return 26'h200_0000;
            4: return 26'h1FF_FFFF;
            5: return span_t'($urandom);
            default: return span_t'($urandom_range(3, 80));
        endcase
    endfunction

    // upper data bits are junk, only the low six bits count
    function automatic span_t pick_flen();
        span_t v;
        v = span_t'($urandom);
        case ($urandom_range(0, 9))
            0: v[FLEN_W-1:0] = 6'd0;
            1: v[FLEN_W-1:0] = 6'd1;
            2: v[FLEN_W-1:0] = 6'd2;
            3: v[FLEN_W-1:0] = 6'd32;
            4: v[FLEN_W-1:0] = 6'd33;
            5: v[FLEN_W-1:0] = 6'd63;
            6: ;
            default: v[FLEN_W-1:0] = FLEN_W'($urandom_range(2, 8));
        endcase
        return v;
    endfunction

    // run starts cluster around zero, the region end and the offset top
    function automatic off_t pick_offset();
        off_t top;
        top = (cfg_size > span_t'(OFF_MAX)) ? OFF_MAX : off_t'(cfg_size - 1'b1);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return OFF_MAX - off_t'($urandom_range(0, 40));
            2: return off_t'(cfg_size) - off_t'($urandom_range(1, 40));
            3: return off_t'($urandom);
            default: return off_t'($urandom_range(0, 32'(top)));
        endcase
    endfunction

    // contiguous runs with random content, mixed with scattered words
    task automatic run_traffic(input int n, input int run_pct);
        int          sent;
        int unsigned len;
        off_t        start;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 99) < run_pct) begin
                len   = $urandom_range(1, 40);
                start = pick_offset();
                for (int unsigned j = 0; j < len; j++)
                    send_byte(start + off_t'(j), byte_t'($urandom));
                sent += int'(len);
            end else begin
                case ($urandom_range(0, 2))
                    0: send_byte(off_t'($urandom), byte_t'($urandom));
                    1: send_byte(last_off, byte_t'($urandom));
                    default: send_byte(last_off + off_t'(2), byte_t'($urandom));
                endcase
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // reset registers, offset counter rolling over, then a contiguity break
    task automatic test_offset_wrap();
        send_byte(OFF_MAX, 8'hFF);
        send_byte(off_t'(0), 8'h00);
        send_byte(off_t'(5), 8'hA5);
    endtask

    // flush length below range, address wrap, exact end, split at end, past end
    task automatic test_region_edges();
        drain_writes();
        program_regs(span_t'(OFF_MAX), span_t'(10), span_t'(0), 1'b0);
        send_byte(off_t'(6), 8'h5A);
        send_byte(off_t'(8), 8'h01);
        send_byte(off_t'(9), 8'h80);
        send_byte(off_t'(9), 8'h7F);
        send_byte(off_t'(10), 8'hFE);
        send_byte(off_t'(1), 8'h33);
        send_byte(off_t'(20), 8'hC3);
        send_byte(off_t'(21), 8'h3C);
    endtask

    // empty region: every burst starts beyond the end
    task automatic test_zero_size_region();
        drain_writes();
        program_regs(span_t'(25'h0AA_AAAA), '0, span_t'(1), 1'b1);
        send_byte(off_t'(3), 8'h55);
        send_byte(off_t'(4), 8'hAA);
        send_byte(OFF_MAX, 8'h0F);
        send_byte(off_t'(0), 8'hF0);
    endtask

    // junk in unused data bits, full-size region split across the offset top
    task automatic test_register_masking();
        drain_writes();
        program_regs({1'b1, 25'h155_5555}, 26'h200_0000, {20'hABCDE, 6'd3}, 1'b0);
        send_byte(OFF_MAX - off_t'(1), 8'h12);
        send_byte(OFF_MAX, 8'h34);
        send_byte(off_t'(0), 8'h56);
        send_byte(off_t'(1), 8'h78);
        send_byte(off_t'(2), 8'h9A);
    endtask

    task automatic test_random_bursts();
        for (int p = 0; p < 6; p++) begin
            drain_writes();
            case (p % 4)
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 50;
                default: stall_pct = 80;
            endcase
            case (p % 3)
                0: gap_max = 0;
                1: gap_max = 2;
                default: gap_max = 8;
            endcase
            case (p)
                0: program_regs(span_t'(OFF_MAX), span_t'(1), span_t'(63), 1'b0);
                5: program_regs('0, '1, span_t'(33), 1'b0);
                default: program_regs(pick_start(), pick_size(), pick_flen(), 1'b0);
            endcase
            run_traffic(15, 80);
            // hold the sender until the block has caught up
            if (p == 2) drain_writes();
            run_traffic(15, 80);
        end
    endtask

    task automatic test_scattered_offsets();
        drain_writes();
        stall_pct = 40;
        gap_max   = 4;
        program_regs(pick_start(), span_t'($urandom_range(2, 40)), span_t'(4), 1'b1);
        run_traffic(70, 20);
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        in_ch.valid  = 1'b0;
        in_ch.word   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.word  = '0;
        out_ch.ready = 1'b0;
        reset_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_offset_wrap();
        test_region_edges();
        test_zero_size_region();
        test_register_masking();
        test_random_bursts();
        test_scattered_offsets();
        drain_writes();

        if (fail_count == 0) begin
            $display("write_combining_buffer_tb: PASS");
        end else begin
            $display("write_combining_buffer_tb: FAIL");
        end
        $finish;
    end

    // hang guard
    initial begin
        #2_000_000;
        $display("write_combining_buffer_tb: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
src/wcb_pkg.sv
src/wcb_if.sv
src/write_combining_buffer.sv
verif/write_combining_buffer_tb.sv
